/* src/clbs_pkg.sv */
// shared constants, types and decode functions for the cache line burst serdes
package clbs_pkg;

  // default configuration
  localparam int WORD_BITS_DEF  = 64;
  localparam int LINE_WORDS_DEF = 4;

  // fixed field widths of the stream words
  localparam int REQ_W  = 3;
  localparam int SIZE_W = 3;
  localparam int IDX_W  = 2;
  localparam int DATA_W = 64;
  localparam int STRB_W = 8;
  localparam int RESP_W = 2;
  localparam int LEN_W  = 4;
  localparam int BSZ_W  = 2;
  localparam int SLOT_OUT_W = 2;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 88;

  // input word field offsets
  localparam int IN_SIZE_LO = 0;
  localparam int IN_IDX_LO  = 3;
  localparam int IN_DATA_LO = 5;
  localparam int IN_STRB_LO = 69;
  localparam int IN_RESP_LO = 77;

  // request kinds carried in tuser
  localparam logic [REQ_W-1:0] REQ_STAGE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RBEAT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_WBEAT = 3'd4;
  localparam logic [REQ_W-1:0] REQ_RESP  = 3'd5;

  // line storage controls from the sequencer
  typedef struct packed {
    logic stage_we;
    logic load_write;
    logic load_read;
    logic gather;
    logic shift;
  } line_ctl_t;

  // result description from the sequencer
  typedef struct packed {
    logic              has_result;
    logic              accepted;
    logic [LEN_W-1:0]  burst_len;
    logic [BSZ_W-1:0]  beat_size;
    logic              beat_last;
    logic              use_head;
    logic              upstream_done;
    logic              resp_valid;
    logic [RESP_W-1:0] resp_out;
    logic              line_done;
  } res_ctl_t;

  // beats minus one for a size code
  function automatic logic [LEN_W-1:0] len_of(input logic [SIZE_W-1:0] sz);
    logic [LEN_W-1:0] len;
    case (sz)
      3'd4:    len = 4'd1;
      3'd5:    len = 4'd3;
      3'd6:    len = 4'd7;
      3'd7:    len = 4'd15;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  // size code clamped to a 64-bit beat
  function automatic logic [BSZ_W-1:0] beat_size_of(input logic [SIZE_W-1:0] sz);
    logic [BSZ_W-1:0] bs;
    if (sz >= 3'd3) begin
      bs = 2'd3;
    end else begin
      bs = sz[BSZ_W-1:0];
    end
    return bs;
  endfunction

endpackage

/* src/cache_line_burst_serdes_core.sv */
// top level: input decode, line storage, result register and read line emitter
//
// channel  dir  handshake                     payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tuser req_type; tdata request fields
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata result fields; tlast beat_last
//
// one word is taken per cycle while the result register is free or being drained;
// each word is decoded and applied in the cycle it is taken
// the last read beat of a line starts a run of LINE_WORDS result words from the line
// registers once emit_busy is set; input is held off during the run, one word per cycle
// unless m_axis stalls; rst clears phase, counters, slot pointer and both line copies
// a stalled m_axis holds the result register and, through tready, the input
module cache_line_burst_serdes_core #(
  parameter int WORD_BITS  = clbs_pkg::WORD_BITS_DEF,
  parameter int LINE_WORDS = clbs_pkg::LINE_WORDS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // size_code, word_index, data_word, byte_strobes, resp_code, zero pad
  input  logic [clbs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // req_type
  input  logic [clbs_pkg::REQ_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // accepted, burst_len, beat_size, out_word, out_strobes, line_slot,
  // upstream_done, resp_valid, resp_out, zero pad
  output logic [clbs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast
);

  localparam int STRB_BITS = WORD_BITS / 8;
  localparam int SLOT_W    = $clog2(LINE_WORDS);

  clbs_pkg::line_ctl_t line_ctl;
  clbs_pkg::res_ctl_t  res;

  logic                   fire;
  logic                   out_load;
  logic                   emit_busy;
  logic [SLOT_W-1:0]      emit_idx;
  logic                   emit_last;
  logic [WORD_BITS-1:0]   data_in;
  logic [STRB_BITS-1:0]   strb_in;
  logic [WORD_BITS-1:0]   rd_word;
  logic [WORD_BITS-1:0]   head_word;
  logic [STRB_BITS-1:0]   head_strb;

  // result register
  logic                              o_accepted;
  logic [clbs_pkg::LEN_W-1:0]        o_burst_len;
  logic [clbs_pkg::BSZ_W-1:0]        o_beat_size;
  logic [clbs_pkg::DATA_W-1:0]       o_word;
  logic [clbs_pkg::STRB_W-1:0]       o_strobes;
  logic                              o_last;
  logic [clbs_pkg::SLOT_OUT_W-1:0]   o_slot;
  logic                              o_upstream_done;
  logic                              o_resp_valid;
  logic [clbs_pkg::RESP_W-1:0]       o_resp;

  // handshakes
  assign out_load      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = out_load && !emit_busy;
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign emit_last     = (emit_idx == SLOT_W'(LINE_WORDS - 1));

  // bus-width slice of the incoming word
  assign data_in = s_axis_tdata[clbs_pkg::IN_DATA_LO +: WORD_BITS];
  assign strb_in = s_axis_tdata[clbs_pkg::IN_STRB_LO +: STRB_BITS];

  clbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .req_type  (s_axis_tuser),
    .size_code (s_axis_tdata[clbs_pkg::IN_SIZE_LO +: clbs_pkg::SIZE_W]),
    .resp_code (s_axis_tdata[clbs_pkg::IN_RESP_LO +: clbs_pkg::RESP_W]),
    .line_ctl  (line_ctl),
    .res       (res)
  );

  clbs_line #(
    .WORD_BITS  (WORD_BITS),
    .LINE_WORDS (LINE_WORDS)
  ) u_line (
    .clk        (clk),
    .rst        (rst),
    .ctl        (line_ctl),
    .word_index (s_axis_tdata[clbs_pkg::IN_IDX_LO +: clbs_pkg::IDX_W]),
    .data_in    (data_in),
    .strb_in    (strb_in),
    .rd_idx     (emit_idx),
    .rd_word    (rd_word),
    .head_word  (head_word),
    .head_strb  (head_strb)
  );

  // output valid and read line run control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      emit_busy     <= 1'b0;
      emit_idx      <= '0;
    end else begin
      if (out_load) begin
        if (emit_busy) begin
          m_axis_tvalid <= 1'b1;
          if (emit_last) begin
            emit_busy <= 1'b0;
          end else begin
            emit_idx <= emit_idx + 1'b1;
          end
        end else begin
          m_axis_tvalid <= fire && res.has_result;
        end
      end
      if (fire && res.line_done) begin
        emit_busy <= 1'b1;
        emit_idx  <= '0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (emit_busy) begin
        o_accepted      <= 1'b0;
        o_burst_len     <= '0;
        o_beat_size     <= '0;
        o_word          <= clbs_pkg::DATA_W'(rd_word);
        o_strobes       <= '0;
        o_last          <= emit_last;
        o_slot          <= clbs_pkg::SLOT_OUT_W'(emit_idx);
        o_upstream_done <= 1'b1;
        o_resp_valid    <= 1'b0;
        o_resp          <= '0;
      end else begin
        o_accepted      <= res.accepted;
        o_burst_len     <= res.burst_len;
        o_beat_size     <= res.beat_size;
        o_word          <= res.use_head ? clbs_pkg::DATA_W'(head_word) : '0;
        o_strobes       <= res.use_head ? clbs_pkg::STRB_W'(head_strb) : '0;
        o_last          <= res.beat_last;
        o_slot          <= '0;
        o_upstream_done <= res.upstream_done;
        o_resp_valid    <= res.resp_valid;
        o_resp          <= res.resp_out;
      end
    end
  end

  // output word packing
  assign m_axis_tdata = {3'b000, o_resp, o_resp_valid, o_upstream_done, o_slot,
                         o_strobes, o_word, o_beat_size, o_burst_len, o_accepted};
  assign m_axis_tlast = o_last;

  // a line run keeps the result register filled
  assert property (@(posedge clk) disable iff (rst)
    emit_busy && out_load |=> m_axis_tvalid)
    else $error("read line run left a gap with the output free");

  // a line run only starts from a taken read beat
  assert property (@(posedge clk) disable iff (rst)
    $rose(emit_busy) |-> $past(fire && res.line_done))
    else $error("line run started without a final read beat");

  // a forwarded response carries no request or line status
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && o_resp_valid |-> !o_accepted && !o_upstream_done)
    else $error("response word mixed with other result kinds");

  // input is held off for the whole line run
  assert property (@(posedge clk) disable iff (rst)
    $past(emit_busy) && emit_busy |-> !s_axis_tready)
    else $error("input taken during a read line run");

endmodule

/* src/clbs_line.sv */
// staged and working line storage with gather, shift and copy paths
module clbs_line #(
  parameter int WORD_BITS  = clbs_pkg::WORD_BITS_DEF,
  parameter int LINE_WORDS = clbs_pkg::LINE_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  clbs_pkg::line_ctl_t             ctl,
  input  logic [clbs_pkg::IDX_W-1:0]      word_index,
  input  logic [WORD_BITS-1:0]            data_in,
  input  logic [WORD_BITS/8-1:0]          strb_in,
  input  logic [$clog2(LINE_WORDS)-1:0]   rd_idx,
  output logic [WORD_BITS-1:0]            rd_word,
  output logic [WORD_BITS-1:0]            head_word,
  output logic [WORD_BITS/8-1:0]          head_strb
);

  localparam int STRB_BITS = WORD_BITS / 8;

  logic [WORD_BITS-1:0] staged_line    [LINE_WORDS];
  logic [STRB_BITS-1:0] staged_strobes [LINE_WORDS];
  logic [WORD_BITS-1:0] work_line      [LINE_WORDS];
  logic [STRB_BITS-1:0] work_strobes   [LINE_WORDS];
  logic [LINE_WORDS-1:0] slot_onehot;

  // staging of write words
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINE_WORDS; i++) begin
        staged_line[i]    <= '0;
        staged_strobes[i] <= '0;
      end
    end else if (ctl.stage_we) begin
      for (int i = 0; i < LINE_WORDS; i++) begin
        if (int'(word_index) == i) begin
          staged_line[i]    <= data_in;
          staged_strobes[i] <= strb_in;
        end
      end
    end
  end

  // working line: copy on write request, slot pointer reset on read request, gather on read beats, shift on write beats
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINE_WORDS; i++) begin
        work_line[i]    <= '0;
        work_strobes[i] <= '0;
      end
      slot_onehot <= '0;
    end else begin
      if (ctl.load_write) begin
        for (int i = 0; i < LINE_WORDS; i++) begin
          work_line[i]    <= staged_line[i];
          work_strobes[i] <= staged_strobes[i];
        end
      end
      if (ctl.load_read) begin
        slot_onehot <= LINE_WORDS'(1);
      end
      if (ctl.gather) begin
        for (int i = 0; i < LINE_WORDS; i++) begin
          if (slot_onehot[i]) begin
            work_line[i] <= data_in;
          end
        end
        slot_onehot <= slot_onehot << 1;
      end
      if (ctl.shift) begin
        for (int i = 0; i < LINE_WORDS - 1; i++) begin
          work_line[i]    <= work_line[i+1];
          work_strobes[i] <= work_strobes[i+1];
        end
        work_line[LINE_WORDS-1]    <= '0;
        work_strobes[LINE_WORDS-1] <= '0;
      end
    end
  end

  // read ports
  assign rd_word   = work_line[rd_idx];
  assign head_word = work_line[0];
  assign head_strb = work_strobes[0];

endmodule

/* src/clbs_ctrl.sv */
// burst sequencer: phase, beat countdown and pending write response
module clbs_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [clbs_pkg::REQ_W-1:0]    req_type,
  input  logic [clbs_pkg::SIZE_W-1:0]   size_code,
  input  logic [clbs_pkg::RESP_W-1:0]   resp_code,
  output clbs_pkg::line_ctl_t           line_ctl,
  output clbs_pkg::res_ctl_t            res
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_READ,
    PH_WRITE
  } phase_t;

  phase_t                     phase, phase_next;
  logic [clbs_pkg::LEN_W-1:0] beats_left, beats_left_next;
  logic                       resp_pending, resp_pending_next;
  logic [clbs_pkg::LEN_W-1:0] len;

  assign len = clbs_pkg::len_of(size_code);

  // per-word decode
  always_comb begin
    phase_next        = phase;
    beats_left_next   = beats_left;
    resp_pending_next = resp_pending;
    line_ctl          = '0;
    res               = '0;
    if (fire) begin
      case (req_type)
        clbs_pkg::REQ_STAGE: begin
          line_ctl.stage_we = 1'b1;
        end
        clbs_pkg::REQ_READ, clbs_pkg::REQ_WRITE: begin
          res.has_result = 1'b1;
          res.burst_len  = len;
          res.beat_size  = clbs_pkg::beat_size_of(size_code);
          if (phase == PH_IDLE) begin
            res.accepted    = 1'b1;
            beats_left_next = len;
            if (req_type == clbs_pkg::REQ_READ) begin
              phase_next         = PH_READ;
              line_ctl.load_read = 1'b1;
            end else begin
              phase_next          = PH_WRITE;
              line_ctl.load_write = 1'b1;
            end
          end
        end
        clbs_pkg::REQ_RBEAT: begin
          if (phase == PH_READ) begin
            line_ctl.gather = 1'b1;
            if (beats_left != '0) begin
              beats_left_next = beats_left - 1'b1;
            end else begin
              phase_next    = PH_IDLE;
              res.line_done = 1'b1;
            end
          end
        end
        clbs_pkg::REQ_WBEAT: begin
          if (phase == PH_WRITE) begin
            res.has_result = 1'b1;
            res.use_head   = 1'b1;
            line_ctl.shift = 1'b1;
            if (beats_left == '0) begin
              res.beat_last     = 1'b1;
              res.upstream_done = 1'b1;
              resp_pending_next = 1'b1;
              phase_next        = PH_IDLE;
            end else begin
              beats_left_next = beats_left - 1'b1;
            end
          end
        end
        clbs_pkg::REQ_RESP: begin
          res.has_result = 1'b1;
          if (resp_pending) begin
            res.resp_valid = 1'b1;
            res.resp_out   = resp_code;
          end
          resp_pending_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      beats_left   <= '0;
      resp_pending <= 1'b0;
    end else begin
      phase        <= phase_next;
      beats_left   <= beats_left_next;
      resp_pending <= resp_pending_next;
    end
  end

endmodule

/* tb/cache_line_burst_serdes_core_tb.sv */
// testbench for the cache line burst serdes core: directed and random traffic against a predictor
`timescale 1ns / 100ps

module cache_line_burst_serdes_core_tb;

  localparam int NUM_SLOTS = clbs_pkg::LINE_WORDS_DEF;
  localparam int RANDOM_ITEMS = 125;
  localparam int DRAIN_CYCLES = 20;

  // request kinds with no function in the block
  localparam logic [clbs_pkg::REQ_W-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [clbs_pkg::REQ_W-1:0] REQ_SPARE7 = 3'd7;

  typedef enum logic [1:0] {BUS_IDLE, BUS_READ, BUS_WRITE} bus_phase_t;

  // one result word split into its fields
  typedef struct {
    logic                        accepted;
    logic [clbs_pkg::LEN_W-1:0]  burst_len;
    logic [clbs_pkg::BSZ_W-1:0]  beat_size;
    logic [clbs_pkg::DATA_W-1:0] word;
    logic [clbs_pkg::STRB_W-1:0] strobes;
    logic                        last;
    logic [1:0]                  slot;
    logic                        done;
    logic                        resp_valid;
    logic [clbs_pkg::RESP_W-1:0] resp;
  } burst_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [clbs_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [clbs_pkg::REQ_W-1:0]       s_axis_tuser = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [clbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tlast;

  // predictor state
  bus_phase_t                  bus_phase = BUS_IDLE;
  logic [clbs_pkg::LEN_W-1:0]  beats_to_go = '0;
  logic                        resp_owed = 1'b0;
  logic [3:0]                  gather_ptr = '0;
  logic [clbs_pkg::DATA_W-1:0] burst_line [NUM_SLOTS];
  logic [clbs_pkg::STRB_W-1:0] burst_strb [NUM_SLOTS];
  logic [clbs_pkg::DATA_W-1:0] staged_words [NUM_SLOTS];
  logic [clbs_pkg::STRB_W-1:0] staged_strb [NUM_SLOTS];

  burst_result_t expected_q [$];
  int unsigned   err_count = 0;
  int unsigned   words_sent = 0;
  int unsigned   results_seen = 0;
  int unsigned   sink_hold = 0;
  bit            quiet = 1'b0;

  cache_line_burst_serdes_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  always #5 clk = ~clk;

  // overall time limit
  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  // beats minus one for a size code
  function automatic logic [clbs_pkg::LEN_W-1:0] burst_len_for(
      input logic [clbs_pkg::SIZE_W-1:0] sz);
    logic [clbs_pkg::LEN_W-1:0] n;
    n = (sz >= 3'd4) ? clbs_pkg::LEN_W'((1 << (sz - 3'd3)) - 1) : '0;
    return n;
  endfunction

  // beat size code, capped at one 64-bit word
  function automatic logic [clbs_pkg::BSZ_W-1:0] beat_size_for(
      input logic [clbs_pkg::SIZE_W-1:0] sz);
    logic [clbs_pkg::BSZ_W-1:0] b;
    b = (sz > 3'd3) ? 2'd3 : sz[clbs_pkg::BSZ_W-1:0];
    return b;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 20);
  endfunction

  // size code weighted toward short bursts
  function automatic logic [clbs_pkg::SIZE_W-1:0] pick_size();
    logic [clbs_pkg::SIZE_W-1:0] sz;
    sz = ($urandom_range(0, 9) < 7) ? clbs_pkg::SIZE_W'($urandom_range(0, 5))
                                    : clbs_pkg::SIZE_W'($urandom_range(6, 7));
    return sz;
  endfunction

  function automatic logic [clbs_pkg::DATA_W-1:0] rand_word();
    logic [clbs_pkg::DATA_W-1:0] w;
    w = {$urandom, $urandom};
    return w;
  endfunction

  // update predictor state for one accepted word and queue its results
  task automatic predict_word(input logic [clbs_pkg::REQ_W-1:0] rt,
                              input logic [clbs_pkg::SIZE_W-1:0] sz,
                              input logic [clbs_pkg::IDX_W-1:0] idx,
                              input logic [clbs_pkg::DATA_W-1:0] data,
                              input logic [clbs_pkg::STRB_W-1:0] strb,
                              input logic [clbs_pkg::RESP_W-1:0] resp);
    burst_result_t r;
    r = '{default: '0};
    case (rt)
      clbs_pkg::REQ_STAGE: begin
        staged_words[idx] = data;
        staged_strb[idx] = strb;
      end
      clbs_pkg::REQ_READ, clbs_pkg::REQ_WRITE: begin
        r.burst_len = burst_len_for(sz);
        r.beat_size = beat_size_for(sz);
        if (bus_phase == BUS_IDLE) begin
          r.accepted = 1'b1;
          beats_to_go = burst_len_for(sz);
          if (rt == clbs_pkg::REQ_READ) begin
            bus_phase = BUS_READ;
            gather_ptr = 4'b0001;
          end else begin
            bus_phase = BUS_WRITE;
            burst_line = staged_words;
            burst_strb = staged_strb;
          end
        end
        expected_q.push_back(r);
      end
      clbs_pkg::REQ_RBEAT: begin
        if (bus_phase == BUS_READ) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (gather_ptr[i]) burst_line[i] = data;
          end
          gather_ptr = gather_ptr << 1;
          if (beats_to_go != 0) begin
            beats_to_go = beats_to_go - 1'b1;
          end else begin
            // whole line goes back as a run of words
            bus_phase = BUS_IDLE;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              r = '{default: '0};
              r.word = burst_line[i];
              r.last = (i == NUM_SLOTS - 1);
              r.slot = 2'(i);
              r.done = 1'b1;
              expected_q.push_back(r);
            end
          end
        end
      end
      clbs_pkg::REQ_WBEAT: begin
        if (bus_phase == BUS_WRITE) begin
          r.word = burst_line[0];
          r.strobes = burst_strb[0];
          r.last = (beats_to_go == 0);
          for (int i = 0; i < NUM_SLOTS - 1; i++) begin
            burst_line[i] = burst_line[i + 1];
            burst_strb[i] = burst_strb[i + 1];
          end
          burst_line[NUM_SLOTS - 1] = '0;
          burst_strb[NUM_SLOTS - 1] = '0;
          if (beats_to_go == 0) begin
            r.done = 1'b1;
            resp_owed = 1'b1;
            bus_phase = BUS_IDLE;
          end else begin
            beats_to_go = beats_to_go - 1'b1;
          end
          expected_q.push_back(r);
        end
      end
      clbs_pkg::REQ_RESP: begin
        if (resp_owed) begin
          r.resp_valid = 1'b1;
          r.resp = resp;
        end
        resp_owed = 1'b0;
        expected_q.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  // present one word on the input, wait for the handshake, then predict
  task automatic send_word(input logic [clbs_pkg::REQ_W-1:0] rt,
                           input logic [clbs_pkg::SIZE_W-1:0] sz,
                           input logic [clbs_pkg::IDX_W-1:0] idx,
                           input logic [clbs_pkg::DATA_W-1:0] data,
                           input logic [clbs_pkg::STRB_W-1:0] strb,
                           input logic [clbs_pkg::RESP_W-1:0] resp);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tuser = rt;
    s_axis_tdata = {1'b0, resp, strb, data, idx, sz};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    predict_word(rt, sz, idx, data, strb, resp);
  endtask

  // word of a given kind with every other field random
  task automatic send_kind(input logic [clbs_pkg::REQ_W-1:0] rt);
    send_word(rt, clbs_pkg::SIZE_W'($urandom_range(0, 7)),
              clbs_pkg::IDX_W'($urandom_range(0, 3)), rand_word(),
              clbs_pkg::STRB_W'($urandom_range(0, 255)),
              clbs_pkg::RESP_W'($urandom_range(0, 3)));
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, want %0h", name, got, want));
  endtask

  // output stall pattern
  always @(negedge clk) begin
    if (sink_hold != 0) begin
      m_axis_tready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      sink_hold <= pick_gap();
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    burst_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %0h", m_axis_tdata));
      end else begin
        want = expected_q.pop_front();
        check_field("accepted", 64'(m_axis_tdata[0]), 64'(want.accepted));
        check_field("burst_len", 64'(m_axis_tdata[4:1]), 64'(want.burst_len));
        check_field("beat_size", 64'(m_axis_tdata[6:5]), 64'(want.beat_size));
        check_field("out_word", m_axis_tdata[70:7], want.word);
        check_field("out_strobes", 64'(m_axis_tdata[78:71]), 64'(want.strobes));
        check_field("line_slot", 64'(m_axis_tdata[80:79]), 64'(want.slot));
        check_field("upstream_done", 64'(m_axis_tdata[81]), 64'(want.done));
        check_field("resp_valid", 64'(m_axis_tdata[82]), 64'(want.resp_valid));
        check_field("resp_out", 64'(m_axis_tdata[84:83]), 64'(want.resp));
        check_field("pad", 64'(m_axis_tdata[87:85]), 64'd0);
        check_field("tlast", 64'(m_axis_tlast), 64'(want.last));
      end
    end
  end

  // idle block: stray beats, unawaited response, spare kinds
  task automatic test_idle_strays();
    send_word(clbs_pkg::REQ_RESP, 3'd0, 2'd0, '0, '0, 2'd3);
    send_word(clbs_pkg::REQ_RBEAT, 3'd7, 2'd3, '1, '1, 2'd0);
    send_word(clbs_pkg::REQ_WBEAT, 3'd5, 2'd1, '1, '1, 2'd1);
    send_word(REQ_SPARE6, 3'd7, 2'd3, '1, '1, 2'd3);
    send_word(REQ_SPARE7, 3'd0, 2'd0, '0, '0, 2'd0);
  endtask

  // four-beat write with extreme data, staging mid-burst and a rejected request
  task automatic test_write_burst();
    send_word(clbs_pkg::REQ_STAGE, 3'd0, 2'd0, '1, 8'hff, 2'd0);
    send_word(clbs_pkg::REQ_STAGE, 3'd7, 2'd1, '0, 8'h00, 2'd3);
    send_word(clbs_pkg::REQ_STAGE, 3'd2, 2'd2, 64'h8000_0000_0000_0001, 8'h81, 2'd1);
    send_word(clbs_pkg::REQ_STAGE, 3'd5, 2'd3, 64'h0123_4567_89ab_cdef, 8'h5a, 2'd2);
    send_word(clbs_pkg::REQ_WRITE, 3'd5, 2'd0, '0, '0, 2'd0);
    send_word(clbs_pkg::REQ_WBEAT, 3'd0, 2'd0, '0, '0, 2'd0);
    // new staged word must not reach the burst in flight
    send_word(clbs_pkg::REQ_STAGE, 3'd0, 2'd2, 64'hdead_beef_cafe_f00d, 8'h3c, 2'd0);
    send_word(clbs_pkg::REQ_READ, 3'd7, 2'd0, '0, '0, 2'd0);
    repeat (3) send_word(clbs_pkg::REQ_WBEAT, 3'd0, 2'd0, '1, '1, 2'd0);
    send_word(clbs_pkg::REQ_RESP, 3'd0, 2'd0, '0, '0, 2'd2);
  endtask

  // eight-beat read: gather into slots, then beats past the line
  task automatic test_read_gather();
    send_word(clbs_pkg::REQ_READ, 3'd6, 2'd0, '0, '0, 2'd0);
    send_word(clbs_pkg::REQ_RBEAT, 3'd0, 2'd0, '1, '0, 2'd0);
    send_word(clbs_pkg::REQ_RBEAT, 3'd0, 2'd0, '0, '0, 2'd0);
    for (int i = 0; i < 6; i++) send_kind(clbs_pkg::REQ_RBEAT);
  endtask

  task automatic test_random_traffic();
    int unsigned first;
    int unsigned pick;
    int unsigned n_beats;
    logic [clbs_pkg::SIZE_W-1:0] sz;
    first = words_sent;
    while (words_sent - first < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        // write: stage some words, request, beats, response
        repeat ($urandom_range(0, 4)) send_kind(clbs_pkg::REQ_STAGE);
        sz = pick_size();
        send_word(clbs_pkg::REQ_WRITE, sz, clbs_pkg::IDX_W'($urandom_range(0, 3)),
                  rand_word(), clbs_pkg::STRB_W'($urandom_range(0, 255)),
                  clbs_pkg::RESP_W'($urandom_range(0, 3)));
        n_beats = burst_len_for(sz) + 1;
        if ($urandom_range(0, 11) == 0) n_beats = $urandom_range(0, n_beats);
        for (int i = 0; i < n_beats; i++) begin
          if ($urandom_range(0, 19) == 0) send_kind(clbs_pkg::REQ_STAGE);
          if ($urandom_range(0, 29) == 0) begin
            send_kind($urandom_range(0, 1) ? clbs_pkg::REQ_READ : clbs_pkg::REQ_WRITE);
          end
          send_kind(clbs_pkg::REQ_WBEAT);
        end
        if ($urandom_range(0, 9) != 0) send_kind(clbs_pkg::REQ_RESP);
      end else if (pick < 8) begin
        // read: request then its beats
        sz = pick_size();
        send_word(clbs_pkg::REQ_READ, sz, clbs_pkg::IDX_W'($urandom_range(0, 3)),
                  rand_word(), clbs_pkg::STRB_W'($urandom_range(0, 255)),
                  clbs_pkg::RESP_W'($urandom_range(0, 3)));
        n_beats = burst_len_for(sz) + 1;
        if ($urandom_range(0, 11) == 0) n_beats = $urandom_range(0, n_beats);
        for (int i = 0; i < n_beats; i++) send_kind(clbs_pkg::REQ_RBEAT);
      end else begin
        // noise of any kind
        repeat ($urandom_range(1, 3)) send_kind(clbs_pkg::REQ_W'($urandom_range(0, 7)));
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      burst_line[i] = '0;
      burst_strb[i] = '0;
      staged_words[i] = '0;
      staged_strb[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_idle_strays();
    test_write_burst();
    test_read_gather();
    test_random_traffic();

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
